// File: src/lpcr_pkg.sv
// Shared types and constants for the LPC signal restore block.
// Used by every module under src; has no dependencies of its own.
`default_nettype none

package lpcr_pkg;

  // Largest predictor order the block is built for.
  localparam int MAX_ORDER_DEFAULT = 32;

  // Depth of the queue between the front end and the engine.
  localparam int QUEUE_DEPTH = 2;

  // Input command codes.
  localparam logic [1:0] CMD_RESIDUAL  = 2'd0;
  localparam logic [1:0] CMD_WARMUP    = 2'd1;
  localparam logic [1:0] CMD_LOAD_COEF = 2'd2;

  // Configuration register indexes.
  localparam logic REG_ORDER = 1'b0;
  localparam logic REG_SHIFT = 1'b1;

  // One classified work item as it travels from the front end to the engine.
  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] sample;
    logic [4:0]  cidx;
    logic [15:0] cval;
    logic        bend;
  } item_t;

  // Engine status seen by the top level.
  typedef struct packed {
    logic busy;
    logic out_free;
  } eng_status_t;

endpackage

`default_nettype wire

// File: src/lpcr_front.sv
// Front end: takes input transfers, drops commands that do nothing and
// hands the rest to the queue. Depends on lpcr_pkg.
`default_nettype none

module lpcr_front #(
  parameter int MAX_ORDER = lpcr_pkg::MAX_ORDER_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          command,
  input  wire logic signed [31:0]  sample_value,
  input  wire logic [4:0]          coef_index,
  input  wire logic signed [15:0]  coef_value,
  input  wire logic                block_end,
  output logic                     push_valid,
  input  wire logic                push_ready,
  output lpcr_pkg::item_t          push_item
);

  logic            hold_valid;
  lpcr_pkg::item_t hold_item;
  logic            keep;

  // The holding register is free when empty or when the queue takes it now.
  assign in_ready = !hold_valid || push_ready;

  // Command three and loads beyond the store are accepted and dropped.
  always_comb begin
    case (command)
      lpcr_pkg::CMD_RESIDUAL:  keep = 1'b1;
      lpcr_pkg::CMD_WARMUP:    keep = 1'b1;
      lpcr_pkg::CMD_LOAD_COEF: keep = (6'(coef_index) < 6'(MAX_ORDER));
      default:                 keep = 1'b0;
    endcase
  end

  // Control of the holding register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid && keep;
    end
  end

  // Payload of the holding register.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_item.op     <= command;
      hold_item.sample <= sample_value;
      hold_item.cidx   <= coef_index;
      hold_item.cval   <= coef_value;
      hold_item.bend   <= block_end;
    end
  end

  assign push_valid = hold_valid;
  assign push_item  = hold_item;

endmodule

`default_nettype wire

// File: src/lpcr_queue.sv
// Short first-in first-out queue of classified items between the front
// end and the engine. Depends on lpcr_pkg.
`default_nettype none

module lpcr_queue (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire lpcr_pkg::item_t  wr_item,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output lpcr_pkg::item_t       rd_item
);

  localparam int DEPTH = lpcr_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  lpcr_pkg::item_t  entries [DEPTH];
  logic [PTR_W-1:0] wptr;
  logic [PTR_W-1:0] rptr;
  logic [CNT_W-1:0] count;
  logic             do_wr;
  logic             do_rd;

  assign wr_ready = (count != CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_item  = entries[rptr];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= (wptr == PTR_W'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= (rptr == PTR_W'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 1'b1;
      end else if (do_rd && !do_wr) begin
        count <= count - 1'b1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wptr] <= wr_item;
    end
  end

endmodule

`default_nettype wire

// File: src/lpcr_engine.sv
// Engine: holds coefficients and sample history, runs the shared
// multiply-accumulate over the taps and drives the result register.
// Depends on lpcr_pkg.
`default_nettype none

module lpcr_engine #(
  parameter int MAX_ORDER = lpcr_pkg::MAX_ORDER_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [5:0]          cfg_order,
  input  wire logic signed [4:0]   cfg_shift,
  input  wire logic                q_valid,
  output logic                     q_ready,
  input  wire lpcr_pkg::item_t     q_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [31:0]       restored_sample,
  output logic                     block_end_out,
  output lpcr_pkg::eng_status_t    status
);

  localparam int IDX_W = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int CNT_W = $clog2(MAX_ORDER + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MAC   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic [31:0]       history [MAX_ORDER];
  logic [15:0]       coefs   [MAX_ORDER];
  logic [CNT_W-1:0]  cnt;
  logic [CNT_W-1:0]  order_eff;
  logic [31:0]       acc;
  logic [31:0]       prod;
  logic              prod_valid;
  logic [31:0]       residual;
  logic              bend;
  logic              out_free;
  logic              pop;
  logic              last_tap;
  logic              push;
  logic [31:0]       push_value;
  logic [31:0]       pred;
  logic [31:0]       res_sum;
  logic [4:0]        left_mag;
  logic signed [47:0] mul;

  // Order is saturated to the store depth.
  assign order_eff = (cfg_order > 6'(MAX_ORDER)) ? CNT_W'(MAX_ORDER) : CNT_W'(cfg_order);
  assign last_tap  = (cnt == CNT_W'(order_eff - CNT_W'(1)));

  assign out_free = !out_valid || out_ready;
  assign q_ready  = (state == S_IDLE) &&
                    ((q_item.op == lpcr_pkg::CMD_LOAD_COEF) || out_free);
  assign pop      = q_valid && q_ready;

  // One tap product; only the low 32 bits matter after wrapping.
  assign mul = $signed(coefs[cnt[IDX_W-1:0]]) * $signed(history[cnt[IDX_W-1:0]]);

  // Scale the prediction: positive shift goes right arithmetically,
  // zero or negative shift goes left by its magnitude.
  assign left_mag = 5'(-cfg_shift);
  always_comb begin
    if (cfg_shift != '0 && !cfg_shift[4]) begin
      pred = 32'($signed(acc) >>> cfg_shift[3:0]);
    end else begin
      pred = acc << left_mag;
    end
  end
  assign res_sum = residual + pred;

  // Sequencer.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (pop && q_item.op == lpcr_pkg::CMD_RESIDUAL) begin
          state_next = (order_eff == '0) ? S_DRAIN : S_MAC;
        end
      end
      S_MAC: begin
        if (last_tap) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: state_next = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Tap counter, product register and accumulator.
  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      cnt        <= '0;
      acc        <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          prod_valid <= 1'b0;
          cnt        <= '0;
          acc        <= '0;
        end
        S_MAC: begin
          prod       <= mul[31:0];
          prod_valid <= 1'b1;
          cnt        <= cnt + 1'b1;
          acc        <= acc + (prod_valid ? prod : 32'd0);
        end
        S_DRAIN: begin
          prod_valid <= 1'b0;
          acc        <= acc + (prod_valid ? prod : 32'd0);
        end
        default: begin
          prod_valid <= 1'b0;
        end
      endcase
    end
  end

  // Residual and block end of the item under work.
  always_ff @(posedge clk) begin
    if (pop && q_item.op == lpcr_pkg::CMD_RESIDUAL) begin
      residual <= q_item.sample;
      bend     <= q_item.bend;
    end
  end

  // A warm-up value or a finished sample enters the history.
  always_comb begin
    push       = 1'b0;
    push_value = q_item.sample;
    if (pop && q_item.op == lpcr_pkg::CMD_WARMUP) begin
      push = 1'b1;
    end else if (state == S_DONE && out_free) begin
      push       = 1'b1;
      push_value = res_sum;
    end
  end

  // History shift line, newest sample at tap zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_ORDER; k++) begin
        history[k] <= '0;
      end
    end else if (push) begin
      for (int k = MAX_ORDER - 1; k > 0; k--) begin
        history[k] <= history[k-1];
      end
      history[0] <= push_value;
    end
  end

  // Coefficient store.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < MAX_ORDER; k++) begin
        coefs[k] <= '0;
      end
    end else if (pop && q_item.op == lpcr_pkg::CMD_LOAD_COEF) begin
      coefs[q_item.cidx[IDX_W-1:0]] <= q_item.cval;
    end
  end

  // Result register control.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk) begin
    if (push) begin
      restored_sample <= push_value;
      block_end_out   <= (state == S_DONE) ? bend : q_item.bend;
    end
  end

  assign status.busy     = (state != S_IDLE);
  assign status.out_free = out_free;

endmodule

`default_nettype wire

// File: src/lpc_signal_restore.sv
// LPC signal restore: a residual sample passes the front register, queue head, one step
// per tap on the shared multiplier, drain and finish to a valid result; a warm-up value
// is echoed after the front register and queue head. The engine takes no new item while
// a residual is in work and other items one per cycle while idle with a free result
// register (loads need only idle), so the tap loop sets throughput. Reset (synchronous,
// active high) clears history, coefficients, queue and sets order to 1 and shift to 0.
`default_nettype none

module lpc_signal_restore #(
  parameter int MAX_ORDER = lpcr_pkg::MAX_ORDER_DEFAULT
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_write,
  input  wire logic                cfg_index,
  input  wire logic [5:0]          cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [1:0]          command,
  input  wire logic signed [31:0]  sample_value,
  input  wire logic [4:0]          coef_index,
  input  wire logic signed [15:0]  coef_value,
  input  wire logic                block_end,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic signed [31:0]       restored_sample,
  output logic                     block_end_out
);

  logic                  cfg_order_wr;
  logic [5:0]            cfg_order;
  logic signed [4:0]     cfg_shift;
  logic                  f_valid;
  logic                  f_ready;
  lpcr_pkg::item_t       f_item;
  logic                  q_valid;
  logic                  q_ready;
  lpcr_pkg::item_t       q_item;
  lpcr_pkg::eng_status_t eng_status;

  assign cfg_order_wr = (cfg_index == lpcr_pkg::REG_ORDER);

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_order <= 6'd1;
      cfg_shift <= '0;
    end else if (cfg_write) begin
      if (cfg_order_wr) begin
        cfg_order <= cfg_data;
      end else begin
        cfg_shift <= cfg_data[4:0];
      end
    end
  end

  lpcr_front #(
    .MAX_ORDER(MAX_ORDER)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (command),
    .sample_value(sample_value),
    .coef_index  (coef_index),
    .coef_value  (coef_value),
    .block_end   (block_end),
    .push_valid  (f_valid),
    .push_ready  (f_ready),
    .push_item   (f_item)
  );

  lpcr_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_valid(f_valid),
    .wr_ready(f_ready),
    .wr_item (f_item),
    .rd_valid(q_valid),
    .rd_ready(q_ready),
    .rd_item (q_item)
  );

  lpcr_engine #(
    .MAX_ORDER(MAX_ORDER)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .cfg_order      (cfg_order),
    .cfg_shift      (cfg_shift),
    .q_valid        (q_valid),
    .q_ready        (q_ready),
    .q_item         (q_item),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .restored_sample(restored_sample),
    .block_end_out  (block_end_out),
    .status         (eng_status)
  );

`ifndef SYNTHESIS
  // A warm-up is taken from the queue only when the result register is free.
  a_warmup_room: assert property (@(posedge clk) disable iff (rst)
    (q_valid && q_ready && q_item.op == lpcr_pkg::CMD_WARMUP) |-> eng_status.out_free)
    else $error("warm-up popped while result register busy");

  // The engine takes nothing from the queue while a residual is in work.
  a_busy_no_pop: assert property (@(posedge clk) disable iff (rst)
    eng_status.busy |-> !q_ready)
    else $error("queue popped while engine busy");

  // No result is shown in the cycle after reset.
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

`default_nettype wire
